>>> hw/rtl/rqi_pkg.sv
package rqi_pkg;

    // coordinate format
    localparam int COORD_FRAC_BITS = 10;
    localparam int COORD_WIDTH     = 21;
    localparam int PACK_WIDTH      = 63;

    // threshold register
    localparam int MIN_DET_WIDTH = 40;
    localparam logic [MIN_DET_WIDTH-1:0] MIN_DET_RESET = MIN_DET_WIDTH'(1074);

    // datapath widths: edges, cross products, single products, dot sums
    localparam int E_W = COORD_WIDTH + 1;
    localparam int X_W = 2 * E_W + 1;
    localparam int P_W = E_W + X_W;
    localparam int D_W = P_W + 2;

    // partial products: cross product split into a signed high and unsigned low half
    localparam int XH_W = X_W - E_W;
    localparam int PP_W = 2 * E_W + 1;

    // threshold alignment from 2^-30 units to 2^-3F units
    localparam int THR_L = (3 * COORD_FRAC_BITS <= 30) ? 30 - 3 * COORD_FRAC_BITS : 0;
    localparam int THR_R = (3 * COORD_FRAC_BITS > 30) ? 3 * COORD_FRAC_BITS - 30 : 0;
    localparam int CMP_W = D_W + MIN_DET_WIDTH + 32;

    // distance divider
    localparam int DIST_W     = 32;
    localparam int DIST_FRAC  = 16;
    localparam int DIV_STAGES = DIST_W;
    localparam int DIV_W      = D_W + DIST_W + 1;
    localparam int FRONT_LAT  = 6;

    typedef struct packed {
        logic [PACK_WIDTH-1:0] ray_origin;
        logic [PACK_WIDTH-1:0] ray_direction;
        logic [PACK_WIDTH-1:0] corner_zero;
        logic [PACK_WIDTH-1:0] corner_one;
        logic [PACK_WIDTH-1:0] corner_two;
        logic [PACK_WIDTH-1:0] corner_three;
        logic                  ignore_back_facing;
    } in_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] hit_distance;
    } out_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] z;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] x;
    } vec_t;

    // per-triangle verdict
    typedef struct packed {
        logic           ok;
        logic [D_W-1:0] adet;
        logic [D_W-1:0] tn;
    } tri_res_t;

    // state of the restoring divider between steps
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              sat;
        logic [DIV_W-1:0]  ds;
        logic [DIV_W-1:0]  rem;
        logic [DIST_W-1:0] quo;
    } div_t;

    function automatic vec_t unpack_vec(input logic [PACK_WIDTH-1:0] w);
        vec_t v;
        v.x = w[COORD_WIDTH-1:0];
        v.y = w[2*COORD_WIDTH-1:COORD_WIDTH];
        v.z = w[3*COORD_WIDTH-1:2*COORD_WIDTH];
        return v;
    endfunction

endpackage

>>> hw/rtl/rqi_tri.sv
module rqi_tri (
    input  logic                          clk,
    input  logic                          en,
    input  rqi_pkg::vec_t                 o,
    input  rqi_pkg::vec_t                 d,
    input  rqi_pkg::vec_t                 a,
    input  rqi_pkg::vec_t                 b,
    input  rqi_pkg::vec_t                 c,
    input  logic [rqi_pkg::MIN_DET_WIDTH-1:0] min_det,
    output rqi_pkg::tri_res_t             res
);
    import rqi_pkg::*;

    logic signed [E_W-1:0] e1_next [3], e2_next [3], tv_next [3], d_next [3];
    logic signed [E_W-1:0] e1_reg [3], e2_reg [3], tv_reg [3], d_reg [3];
    logic signed [E_W-1:0] e1b_reg [3], e2b_reg [3], tvb_reg [3], db_reg [3];
    logic signed [X_W-1:0] p_next [3], q_next [3], p_reg [3], q_reg [3];
    logic signed [PP_W-1:0] prl_next [12], prh_next [12], prl_reg [12], prh_reg [12];
    logic signed [D_W-1:0] det_next, un_next, vn_next, tn_next;
    logic signed [D_W-1:0] det_reg, un_reg, vn_reg, tn_reg;
    logic                  zero_next, zero_reg;
    logic signed [D_W-1:0] adet_next, unn_next, vnn_next, tnn_next;
    logic signed [D_W-1:0] adet_reg, unn_reg, vnn_reg, tnn_reg;
    logic [CMP_W-1:0]      thr_lhs, thr_rhs;
    logic [D_W:0]          uv_sum;
    tri_res_t              res_next, res_reg;

    // high partial product times 2^E_W plus low partial product
    function automatic logic signed [D_W-1:0] join_pp(input logic signed [PP_W-1:0] h,
                                                      input logic signed [PP_W-1:0] l);
        return (D_W'(h) <<< E_W) + D_W'(l);
    endfunction

    // one edge component times the low half of a cross product component
    function automatic logic signed [PP_W-1:0] mul_lo(input logic signed [E_W-1:0] e,
                                                     input logic signed [X_W-1:0] x);
        return PP_W'(e * $signed({1'b0, x[E_W-1:0]}));
    endfunction

    // one edge component times the high half of a cross product component
    function automatic logic signed [PP_W-1:0] mul_hi(input logic signed [E_W-1:0] e,
                                                     input logic signed [X_W-1:0] x);
        return PP_W'(e * $signed(x[X_W-1:E_W]));
    endfunction

    // edges and origin offset
    always_comb
    begin
        e1_next[0] = E_W'(b.x) - E_W'(a.x);
        e1_next[1] = E_W'(b.y) - E_W'(a.y);
        e1_next[2] = E_W'(b.z) - E_W'(a.z);
        e2_next[0] = E_W'(c.x) - E_W'(a.x);
        e2_next[1] = E_W'(c.y) - E_W'(a.y);
        e2_next[2] = E_W'(c.z) - E_W'(a.z);
        tv_next[0] = E_W'(o.x) - E_W'(a.x);
        tv_next[1] = E_W'(o.y) - E_W'(a.y);
        tv_next[2] = E_W'(o.z) - E_W'(a.z);
        d_next[0]  = E_W'(d.x);
        d_next[1]  = E_W'(d.y);
        d_next[2]  = E_W'(d.z);
    end

    // p = d x e2, q = tv x e1
    always_comb
    begin
        p_next[0] = X_W'(d_reg[1] * e2_reg[2]) - X_W'(d_reg[2] * e2_reg[1]);
        p_next[1] = X_W'(d_reg[2] * e2_reg[0]) - X_W'(d_reg[0] * e2_reg[2]);
        p_next[2] = X_W'(d_reg[0] * e2_reg[1]) - X_W'(d_reg[1] * e2_reg[0]);
        q_next[0] = X_W'(tv_reg[1] * e1_reg[2]) - X_W'(tv_reg[2] * e1_reg[1]);
        q_next[1] = X_W'(tv_reg[2] * e1_reg[0]) - X_W'(tv_reg[0] * e1_reg[2]);
        q_next[2] = X_W'(tv_reg[0] * e1_reg[1]) - X_W'(tv_reg[1] * e1_reg[0]);
    end

    // dot product terms as high and low partial products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prl_next[i]     = mul_lo(e1b_reg[i], p_reg[i]);
            prh_next[i]     = mul_hi(e1b_reg[i], p_reg[i]);
            prl_next[3 + i] = mul_lo(tvb_reg[i], p_reg[i]);
            prh_next[3 + i] = mul_hi(tvb_reg[i], p_reg[i]);
            prl_next[6 + i] = mul_lo(db_reg[i], q_reg[i]);
            prh_next[6 + i] = mul_hi(db_reg[i], q_reg[i]);
            prl_next[9 + i] = mul_lo(e2b_reg[i], q_reg[i]);
            prh_next[9 + i] = mul_hi(e2b_reg[i], q_reg[i]);
        end
    end

    // dot sums
    always_comb
    begin
        det_next = join_pp(prh_reg[0], prl_reg[0]) + join_pp(prh_reg[1], prl_reg[1])
                 + join_pp(prh_reg[2], prl_reg[2]);
        un_next  = join_pp(prh_reg[3], prl_reg[3]) + join_pp(prh_reg[4], prl_reg[4])
                 + join_pp(prh_reg[5], prl_reg[5]);
        vn_next  = join_pp(prh_reg[6], prl_reg[6]) + join_pp(prh_reg[7], prl_reg[7])
                 + join_pp(prh_reg[8], prl_reg[8]);
        tn_next  = join_pp(prh_reg[9], prl_reg[9]) + join_pp(prh_reg[10], prl_reg[10])
                 + join_pp(prh_reg[11], prl_reg[11]);
    end

    // fold the determinant sign into the numerators
    always_comb
    begin
        zero_next = (det_reg == '0);
        if (det_reg[D_W-1])
        begin
            adet_next = -det_reg;
            unn_next  = -un_reg;
            vnn_next  = -vn_reg;
            tnn_next  = -tn_reg;
        end
        else
        begin
            adet_next = det_reg;
            unn_next  = un_reg;
            vnn_next  = vn_reg;
            tnn_next  = tn_reg;
        end
    end

    // bound tests
    always_comb
    begin
        thr_lhs = CMP_W'(unsigned'(adet_reg)) << THR_L;
        thr_rhs = CMP_W'(min_det) << THR_R;
        uv_sum  = {1'b0, unsigned'(unn_reg)} + {1'b0, unsigned'(vnn_reg)};
        res_next.ok = !zero_reg && (thr_lhs >= thr_rhs)
                      && !unn_reg[D_W-1] && (unsigned'(unn_reg) <= unsigned'(adet_reg))
                      && !vnn_reg[D_W-1] && (uv_sum <= {1'b0, unsigned'(adet_reg)})
                      && !tnn_reg[D_W-1];
        res_next.adet = unsigned'(adet_reg);
        res_next.tn   = unsigned'(tnn_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            tv_reg   <= tv_next;
            d_reg    <= d_next;
            p_reg    <= p_next;
            q_reg    <= q_next;
            e1b_reg  <= e1_reg;
            e2b_reg  <= e2_reg;
            tvb_reg  <= tv_reg;
            db_reg   <= d_reg;
            prl_reg  <= prl_next;
            prh_reg  <= prh_next;
            det_reg  <= det_next;
            un_reg   <= un_next;
            vn_reg   <= vn_next;
            tn_reg   <= tn_next;
            zero_reg <= zero_next;
            adet_reg <= adet_next;
            unn_reg  <= unn_next;
            vnn_reg  <= vnn_next;
            tnn_reg  <= tnn_next;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> hw/rtl/rqi_div_step.sv
module rqi_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  rqi_pkg::div_t d_in,
    output rqi_pkg::div_t d_out
);
    import rqi_pkg::*;

    logic valid_reg;
    div_t data_next, data_reg;

    // one restoring quotient bit
    always_comb
    begin
        data_next    = d_in;
        data_next.ds = d_in.ds >> 1;
        if (d_in.ds <= d_in.rem)
        begin
            data_next.rem = d_in.rem - d_in.ds;
            data_next.quo = {d_in.quo[DIST_W-2:0], 1'b1};
        end
        else
        begin
            data_next.quo = {d_in.quo[DIST_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= d_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

>>> hw/rtl/ray_quad_intersect_unit.sv
// Ray versus quad hit test. Each beat on the input carries a ray and the four
// corners of a quad; each produces exactly one result beat with the hit flag
// and the hit distance t (unsigned Q16.16, saturated, zero on a miss). The
// pipeline accepts one beat per clock unless stalled and is built from six
// stages of edge, cross product, dot product and bound logic (both triangles
// evaluated side by side), one select stage, one stage per quotient bit of the
// 32-bit restoring divider, and the output register. An output stall freezes
// the whole pipeline. min_determinant is written through the cfg channel,
// which is always ready; write it only while no beats are in flight.
module ray_quad_intersect_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rqi_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rqi_pkg::out_t                     out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rqi_pkg::MIN_DET_WIDTH-1:0] cfg_data
);
    import rqi_pkg::*;

    logic                     adv;
    logic [MIN_DET_WIDTH-1:0] min_det_reg;
    logic [FRONT_LAT-1:0]     fv_reg, bf_reg;
    vec_t                     o, d, c0, c1, c2, c3;
    tri_res_t                 res0, res1, rsel;
    logic                     bf_in;
    div_t                     sel_next, sel_reg;
    logic                     sel_valid_reg;
    div_t                     chain [DIV_STAGES+1];
    logic                     out_valid_reg;
    out_t                     out_next, out_reg;

    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_det_reg <= MIN_DET_RESET;
        else if (cfg_valid && cfg_ready)
            min_det_reg <= cfg_data;
    end

    // unpack coordinates
    always_comb
    begin
        o     = unpack_vec(in_data.ray_origin);
        d     = unpack_vec(in_data.ray_direction);
        c0    = unpack_vec(in_data.corner_zero);
        c1    = unpack_vec(in_data.corner_one);
        c2    = unpack_vec(in_data.corner_two);
        c3    = unpack_vec(in_data.corner_three);
        bf_in = in_data.ignore_back_facing && (d.z <= 0);
    end

    rqi_tri u_tri0 (
        .clk     (clk),
        .en      (adv),
        .o       (o),
        .d       (d),
        .a       (c0),
        .b       (c1),
        .c       (c2),
        .min_det (min_det_reg),
        .res     (res0)
    );

    rqi_tri u_tri1 (
        .clk     (clk),
        .en      (adv),
        .o       (o),
        .d       (d),
        .a       (c0),
        .b       (c2),
        .c       (c3),
        .min_det (min_det_reg),
        .res     (res1)
    );

    // valid and back-face flags alongside the triangle pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else if (adv)
            fv_reg <= {fv_reg[FRONT_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            bf_reg <= {bf_reg[FRONT_LAT-2:0], bf_in};
    end

    // pick the first triangle that hits and seed the divider
    always_comb
    begin
        rsel           = res0.ok ? res0 : res1;
        sel_next.valid = fv_reg[FRONT_LAT-1];
        sel_next.hit   = !bf_reg[FRONT_LAT-1] && (res0.ok || res1.ok);
        sel_next.rem   = DIV_W'(rsel.tn) << DIST_FRAC;
        sel_next.ds    = DIV_W'(rsel.adet) << (DIST_W - 1);
        sel_next.sat   = (DIV_W'(rsel.tn) << DIST_FRAC) >= (DIV_W'(rsel.adet) << DIST_W);
        sel_next.quo   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_valid_reg <= 1'b0;
        else if (adv)
            sel_valid_reg <= sel_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sel_reg <= sel_next;
    end

    // quotient bits, most significant first
    assign chain[0] = '{valid: sel_valid_reg, hit: sel_reg.hit, sat: sel_reg.sat,
                        ds: sel_reg.ds, rem: sel_reg.rem, quo: sel_reg.quo};

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        rqi_div_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d_in  (chain[k]),
            .d_out (chain[k+1])
        );
    end

    // result beat
    always_comb
    begin
        out_next.hit = chain[DIV_STAGES].hit;
        if (!chain[DIV_STAGES].hit)
            out_next.hit_distance = '0;
        else if (chain[DIV_STAGES].sat)
            out_next.hit_distance = '1;
        else
            out_next.hit_distance = chain[DIV_STAGES].quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= chain[DIV_STAGES].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a miss never reports a distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.hit_distance == '0)
        else $error("miss with nonzero distance");

    // a stall freezes the divider chain
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(sel_valid_reg) && $stable(chain[DIV_STAGES].valid))
        else $error("pipeline moved under stall");

    // threshold write lands
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> min_det_reg == $past(cfg_data))
        else $error("threshold write lost");

endmodule
